// File: rtl/rait_pkg.sv
package rait_pkg;

	localparam int STACK_DEPTH_DEF      = 32;
	localparam int INDIRECT_ENTRIES_DEF = 4096;
	localparam int SIZE_ENTRIES_DEF     = 1024;

	localparam int IN_DATA_W  = 136;
	localparam int IN_USER_W  = 4;
	localparam int OUT_DATA_W = 72;

	localparam logic [2:0] KIND_INDIRECT      = 3'd2;
	localparam logic [2:0] KIND_CONDITIONAL   = 3'd3;
	localparam logic [2:0] KIND_DIRECT_CALL   = 3'd4;
	localparam logic [2:0] KIND_INDIRECT_CALL = 3'd5;
	localparam logic [2:0] KIND_RETURN        = 3'd6;

	localparam logic        OP_UPDATE        = 1'b1;
	localparam logic [63:0] SIZE_LEARN_LIMIT = 64'd10;
	localparam logic [3:0]  SIZE_AT_RESET    = 4'd4;

	typedef struct packed {
		logic        upd;
		logic        is_ret;
		logic        is_ind;
		logic        is_cond;
		logic        is_call;
		logic [63:0] addr;
		logic [63:0] target;
		logic        taken;
	} item_t;

endpackage

// File: rtl/rait_front.sv
module rait_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [rait_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  logic [rait_pkg::IN_USER_W-1:0]   s_axis_tuser,
	output logic                             q_valid,
	output rait_pkg::item_t                  q_item,
	input  logic                             q_pop
);
	import rait_pkg::*;

	item_t      dec;
	item_t      fifo_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic [2:0] kind;

	assign kind = s_axis_tuser[3:1];

	always_comb begin
		dec         = '0;
		dec.upd     = (s_axis_tuser[0] == OP_UPDATE);
		dec.addr    = s_axis_tdata[63:0];
		dec.target  = s_axis_tdata[127:64];
		dec.taken   = s_axis_tdata[128];
		unique case (kind)
			KIND_INDIRECT: begin
				dec.is_ind = 1'b1;
			end
			KIND_CONDITIONAL: begin
				dec.is_cond = 1'b1;
			end
			KIND_DIRECT_CALL: begin
				dec.is_call = 1'b1;
			end
			KIND_INDIRECT_CALL: begin
				dec.is_call = 1'b1;
				dec.is_ind  = 1'b1;
			end
			KIND_RETURN: begin
				dec.is_ret = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign s_axis_tready = (cnt_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (cnt_q != 2'd0);
	assign q_item        = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

// File: rtl/rait_back.sv
module rait_back #(
	parameter int STACK_DEPTH      = rait_pkg::STACK_DEPTH_DEF,
	parameter int INDIRECT_ENTRIES = rait_pkg::INDIRECT_ENTRIES_DEF,
	parameter int SIZE_ENTRIES     = rait_pkg::SIZE_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  rait_pkg::item_t                 q_item,
	output logic                            q_pop,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [rait_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import rait_pkg::*;

	localparam int TW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int IW    = $clog2(INDIRECT_ENTRIES);
	localparam int SZW   = $clog2(SIZE_ENTRIES);
	localparam int CLR_N = (INDIRECT_ENTRIES > SIZE_ENTRIES) ? INDIRECT_ENTRIES : SIZE_ENTRIES;
	localparam int CW    = $clog2(CLR_N);

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_SZ   = 2'd3;

	logic [1:0]  state_q;
	logic [CW-1:0] clr_q;
	item_t       item_q;
	logic [TW-1:0] top_q;
	logic [IW-1:0] hist_q;
	logic [STACK_DEPTH-1:0] vld_q;

	logic [63:0] stk_mem [STACK_DEPTH];
	logic [63:0] ind_mem [INDIRECT_ENTRIES];
	logic [3:0]  sz_mem  [SIZE_ENTRIES];

	logic [63:0] stk_rd_s1;
	logic        vld_s1;
	logic [63:0] ind_rd_s1;
	logic [3:0]  sz_rd_s1;
	logic [63:0] base_q;

	logic [63:0] pred_q;
	logic        ptaken_q;
	logic        has_q;
	logic        out_vld_q;

	logic [IW-1:0]  ind_raddr;
	logic [IW-1:0]  ind_waddr;
	logic           ind_we;
	logic [63:0]    ind_wdata;
	logic [SZW-1:0] sz_raddr;
	logic [SZW-1:0] sz_waddr;
	logic           sz_we;
	logic [3:0]     sz_wdata;
	logic [TW-1:0]  top_inc;
	logic [TW-1:0]  top_dec;
	logic [63:0]    top_val;
	logic [63:0]    call_gap;
	logic           clr_last;

	assign ind_raddr = q_item.addr[IW+1:2] ^ hist_q;
	assign top_val   = vld_s1 ? stk_rd_s1 : 64'd0;
	assign sz_raddr  = top_val[SZW-1:0];
	assign top_inc   = (top_q == TW'(STACK_DEPTH - 1)) ? '0 : top_q + TW'(1);
	assign top_dec   = (top_q == '0) ? TW'(STACK_DEPTH - 1) : top_q - TW'(1);
	assign call_gap  = (top_val > item_q.target) ? top_val - item_q.target
	                                             : item_q.target - top_val;
	assign clr_last  = (clr_q == CW'(CLR_N - 1));
	assign q_pop     = (state_q == ST_IDLE) && q_valid && !out_vld_q;

	always_comb begin
		ind_we    = 1'b0;
		ind_waddr = item_q.addr[IW+1:2] ^ hist_q;
		ind_wdata = item_q.target;
		sz_we     = 1'b0;
		sz_waddr  = top_val[SZW-1:0];
		sz_wdata  = call_gap[3:0];
		if (state_q == ST_CLR) begin
			ind_we    = ({1'b0, clr_q} < (CW+1)'(INDIRECT_ENTRIES));
			ind_waddr = clr_q[IW-1:0];
			ind_wdata = 64'd0;
			sz_we     = ({1'b0, clr_q} < (CW+1)'(SIZE_ENTRIES));
			sz_waddr  = clr_q[SZW-1:0];
			sz_wdata  = SIZE_AT_RESET;
		end else if (state_q == ST_RD && item_q.upd) begin
			ind_we = item_q.is_ind;
			sz_we  = item_q.is_ret && (call_gap <= SIZE_LEARN_LIMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (ind_we) begin
			ind_mem[ind_waddr] <= ind_wdata;
		end
		if (sz_we) begin
			sz_mem[sz_waddr] <= sz_wdata;
		end
		if (state_q == ST_RD && !item_q.upd && item_q.is_call) begin
			stk_mem[top_inc] <= item_q.addr;
		end
		ind_rd_s1 <= ind_mem[ind_raddr];
		sz_rd_s1  <= sz_mem[sz_raddr];
		stk_rd_s1 <= stk_mem[top_q];
		vld_s1    <= vld_q[top_q];
		if (q_pop) begin
			item_q <= q_item;
		end
		if (state_q == ST_RD) begin
			base_q <= top_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			top_q     <= '0;
			hist_q    <= '0;
			vld_q     <= '0;
			out_vld_q <= 1'b0;
			pred_q    <= 64'd0;
			ptaken_q  <= 1'b0;
			has_q     <= 1'b0;
		end else begin
			if (out_vld_q && m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q  <= ST_IDLE;
					pred_q   <= 64'd0;
					ptaken_q <= 1'b0;
					has_q    <= 1'b0;
					if (!item_q.upd) begin
						ptaken_q <= !item_q.is_cond;
						if (item_q.is_call) begin
							top_q        <= top_inc;
							vld_q[top_inc] <= 1'b1;
						end
						if (item_q.is_ret) begin
							state_q <= ST_SZ;
						end else begin
							out_vld_q <= 1'b1;
							if (item_q.is_ind) begin
								pred_q <= ind_rd_s1;
								has_q  <= 1'b1;
							end
						end
					end else begin
						out_vld_q <= 1'b1;
						if (item_q.is_cond) begin
							hist_q <= {hist_q[IW-2:0], item_q.taken};
						end
						if (item_q.is_ret) begin
							vld_q[top_q] <= 1'b0;
							top_q        <= top_dec;
						end
					end
				end
				ST_SZ: begin
					state_q   <= ST_IDLE;
					pred_q    <= base_q + {60'd0, sz_rd_s1};
					ptaken_q  <= 1'b1;
					has_q     <= 1'b1;
					out_vld_q <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {6'd0, has_q, ptaken_q, pred_q};

endmodule

// File: rtl/return_and_indirect_target_predictor_unit.sv
// return address stack and indirect target table
// input channel s_axis: one predict or update item per handshake
//   tuser carries operation and branch kind, tdata the addresses and taken bit
// output channel m_axis: exactly one result item per input item, in order
// front decodes the kind and queues up to two items; back runs them
// result: held in the output register; a predicted return first goes through
//   a stack read, then a call size read, then an add
// issue: back takes the next item only once it is idle and the output register is empty,
//   so a new item is not taken while the last one is in flight or its result waits
// reset: stack top, history and stack valid bits clear at once; then a sweep
//   over max(INDIRECT_ENTRIES, SIZE_ENTRIES) entries (4096 by default) clears the
//   target table and sets call sizes to four; up to two items queue meanwhile
// stall: a result waits in the output register while m_axis_tready is low,
//   the queue keeps taking items until full, then s_axis_tready drops
module return_and_indirect_target_predictor_unit #(
	parameter int STACK_DEPTH      = rait_pkg::STACK_DEPTH_DEF,
	parameter int INDIRECT_ENTRIES = rait_pkg::INDIRECT_ENTRIES_DEF,
	parameter int SIZE_ENTRIES     = rait_pkg::SIZE_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// branch_address, resolved_target, was_taken, zero fill
	input  logic [rait_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// operation, kind
	input  logic [rait_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// predicted_target, predict_taken, has_prediction, zero fill
	output logic [rait_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import rait_pkg::*;

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	rait_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	rait_back #(
		.STACK_DEPTH      (STACK_DEPTH),
		.INDIRECT_ENTRIES (INDIRECT_ENTRIES),
		.SIZE_ENTRIES     (SIZE_ENTRIES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// File: rtl/rait_chk.sv
module rait_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [rait_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	logic [2:0] pend_q;

	// items accepted at the input and not yet taken at the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(s_axis_tvalid && s_axis_tready)
				- 3'(m_axis_tvalid && m_axis_tready);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[71:66] == 6'd0)
		else $error("fill bits not zero");

	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[65] |-> m_axis_tdata[63:0] == 64'd0)
		else $error("target without prediction");

	a_has_taken: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[65] |-> m_axis_tdata[64])
		else $error("prediction not taken");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != 3'd0)
		else $error("result without input item");

endmodule

bind return_and_indirect_target_predictor_unit rait_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: test/return_and_indirect_target_predictor_unit_tb.sv
`timescale 1ns / 100ps

module return_and_indirect_target_predictor_unit_tb;
	import rait_pkg::*;

	localparam int DEPTH = STACK_DEPTH_DEF;
	localparam int TBL_N = INDIRECT_ENTRIES_DEF;
	localparam int SZ_N  = SIZE_ENTRIES_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	localparam logic [2:0] KIND_OTHER  = 3'd0;
	localparam logic [2:0] KIND_DIRECT = 3'd1;
	localparam logic [2:0] KIND_UNUSED = 3'd7;
	localparam logic       OP_PREDICT  = 1'b0;

	typedef struct packed {
		logic [63:0] target;
		logic        taken;
		logic        has;
	} branch_result_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic [IN_USER_W-1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	logic [63:0] ras [DEPTH];
	int unsigned ras_top;
	logic [63:0] target_tbl [TBL_N];
	logic [11:0] cond_hist;
	logic [3:0] call_len [SZ_N];

	branch_result_t pending_results[$];
	int errors;
	int results_seen;
	int idle_cycles;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_recv;
	int hold_len;
	logic [63:0] recent_calls[$];

	return_and_indirect_target_predictor_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic logic [11:0] tbl_idx(logic [63:0] addr);
		return addr[13:2] ^ cond_hist;
	endfunction

	function automatic branch_result_t predict_branch(logic op, logic [63:0] addr,
			logic [2:0] kind, logic [63:0] tgt, logic tk);
		branch_result_t r;
		logic [63:0] top;
		logic [63:0] gap;
		r = '0;
		if (op == OP_PREDICT) begin
			r.taken = (kind != KIND_CONDITIONAL);
			if (kind == KIND_DIRECT_CALL || kind == KIND_INDIRECT_CALL) begin
				ras_top = (ras_top + 1) % DEPTH;
				ras[ras_top] = addr;
			end
			if (kind == KIND_RETURN) begin
				top = ras[ras_top];
				r.target = top + 64'(call_len[top[9:0]]);
				r.has = 1'b1;
			end else if (kind == KIND_INDIRECT || kind == KIND_INDIRECT_CALL) begin
				r.target = target_tbl[tbl_idx(addr)];
				r.has = 1'b1;
			end
		end else begin
			if (kind == KIND_INDIRECT || kind == KIND_INDIRECT_CALL) begin
				target_tbl[tbl_idx(addr)] = tgt;
			end else if (kind == KIND_CONDITIONAL) begin
				cond_hist = {cond_hist[10:0], tk};
			end else if (kind == KIND_RETURN) begin
				top = ras[ras_top];
				ras[ras_top] = '0;
				ras_top = (ras_top == 0) ? DEPTH - 1 : ras_top - 1;
				gap = (top > tgt) ? top - tgt : tgt - top;
				if (gap <= SIZE_LEARN_LIMIT)
					call_len[top[9:0]] = gap[3:0];
			end
		end
		return r;
	endfunction

	task automatic send_branch(logic op, logic [63:0] addr, logic [2:0] kind,
			logic [63:0] tgt, logic tk);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'b0, tk, tgt, addr};
		s_axis_tuser <= {kind, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_results = {pending_results, predict_branch(op, addr, kind, tgt, tk)};
		if (op == OP_PREDICT && (kind == KIND_DIRECT_CALL || kind == KIND_INDIRECT_CALL))
			recent_calls = {recent_calls, addr};
		if (recent_calls.size() > 16)
			void'(recent_calls.pop_front());
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64;
		return {$urandom, $urandom};
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_recv) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		branch_result_t got;
		branch_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[63:0], m_axis_tdata[64], m_axis_tdata[65]};
			results_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $time, got);
			end else begin
				want = pending_results.pop_front();
				if (got.target !== want.target) begin
					errors++;
					$display("%0t: target expected %h actual %h", $time, want.target,
						got.target);
				end
				if (got.taken !== want.taken) begin
					errors++;
					$display("%0t: taken expected %b actual %b", $time, want.taken, got.taken);
				end
				if (got.has !== want.has) begin
					errors++;
					$display("%0t: has_prediction expected %b actual %b", $time, want.has,
						got.has);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT + 6000) begin
			$display("return_and_indirect_target_predictor_unit: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_len > 0) begin
			hold_len <= hold_len - 1;
			if (hold_len == 1)
				hold_recv <= 1'b0;
		end
	end

	task automatic test_directed;
		logic [2:0] k;
		for (int i = 0; i < 8; i++) begin
			k = 3'(i);
			send_branch(OP_PREDICT, 64'h1000 + 64'(i * 4), k, '0, 1'b0);
		end
		send_branch(OP_UPDATE, 64'h2000, KIND_INDIRECT, '1, 1'b1);
		send_branch(OP_PREDICT, 64'h2000, KIND_INDIRECT, '0, 1'b0);
		send_branch(OP_UPDATE, '1, KIND_INDIRECT_CALL, 64'h5555_aaaa_0000_ffff, 1'b0);
		send_branch(OP_PREDICT, '1, KIND_INDIRECT_CALL, '0, 1'b0);
		send_branch(OP_UPDATE, '0, KIND_CONDITIONAL, '0, 1'b1);
		send_branch(OP_UPDATE, '0, KIND_CONDITIONAL, '1, 1'b0);
		send_branch(OP_PREDICT, 64'hffff_ffff_ffff_fff8, KIND_DIRECT_CALL, '0, 1'b0);
		send_branch(OP_PREDICT, '0, KIND_RETURN, '0, 1'b0);
		send_branch(OP_UPDATE, '0, KIND_RETURN, 64'h2, 1'b0);
		send_branch(OP_UPDATE, '0, KIND_RETURN, 64'd10, 1'b0);
		send_branch(OP_UPDATE, '0, KIND_RETURN, 64'd11, 1'b1);
		send_branch(OP_UPDATE, 64'h40, KIND_OTHER, '1, 1'b1);
		send_branch(OP_UPDATE, 64'h40, KIND_DIRECT, '1, 1'b1);
		send_branch(OP_UPDATE, 64'h40, KIND_INDIRECT, '1, 1'b1);
		send_branch(OP_UPDATE, '0, KIND_UNUSED, '1, 1'b1);
		drain();
	endtask

	task automatic random_branch;
		logic [63:0] addr;
		logic [63:0] base;
		logic [2:0] kind;
		int sel;
		sel = $urandom_range(99);
		addr = ($urandom_range(3) == 0) ? rand64() : 64'($urandom_range(4095)) << 2;
		if (sel < 15) begin
			send_branch(OP_PREDICT, addr, $urandom_range(1) ? KIND_DIRECT_CALL
				: KIND_INDIRECT_CALL, rand64(), 1'($urandom_range(1)));
		end else if (sel < 35) begin
			base = (recent_calls.size() != 0)
				? recent_calls[$urandom_range(recent_calls.size() - 1)] : addr;
			send_branch(OP_PREDICT, addr, KIND_RETURN, rand64(), 1'($urandom_range(1)));
			send_branch(OP_UPDATE, addr, KIND_RETURN, ($urandom_range(3) == 0) ? rand64()
				: base + 64'($urandom_range(12)) - 64'd1, 1'($urandom_range(1)));
		end else if (sel < 55) begin
			kind = $urandom_range(1) ? KIND_INDIRECT : KIND_INDIRECT_CALL;
			send_branch(OP_UPDATE, addr, kind, rand64(), 1'($urandom_range(1)));
			send_branch(OP_PREDICT, addr, kind, rand64(), 1'($urandom_range(1)));
		end else if (sel < 70) begin
			send_branch(OP_UPDATE, rand64(), KIND_CONDITIONAL, rand64(),
				1'($urandom_range(1)));
		end else begin
			send_branch(1'($urandom_range(1)), addr, 3'($urandom_range(7)), rand64(),
				1'($urandom_range(1)));
		end
	endtask

	task automatic test_random(int n, int s_pct, int r_pct);
		send_idle_pct = s_pct;
		recv_stall_pct = r_pct;
		for (int i = 0; i < n; i++)
			random_branch();
		send_idle_pct = 0;
		drain();
	endtask

	task automatic test_backpressure;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_recv <= 1'b1;
		hold_len <= 60;
		for (int i = 0; i < 20; i++)
			random_branch();
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		errors = 0;
		results_seen = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_recv = 1'b0;
		hold_len = 0;
		ras_top = 0;
		cond_hist = '0;
		foreach (ras[i]) ras[i] = '0;
		foreach (target_tbl[i]) target_tbl[i] = '0;
		foreach (call_len[i]) call_len[i] = SIZE_AT_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(240, 0, 0);
		test_random(240, 67, 0);
		test_random(240, 0, 67);
		test_random(240, 32, 32);
		test_backpressure();
		test_random(240, 0, 0);
		$display("covered predict and update of all kinds, stack wrap, call size learning,");
		$display("indirect table aliasing by history, with idle, stall and backpressure phases");
		if (errors == 0)
			$display("return_and_indirect_target_predictor_unit: match");
		else
			$display("return_and_indirect_target_predictor_unit: mismatch");
		$finish;
	end

endmodule
